// ===== src/kfli_pkg.sv =====
// Package with the constants, types and field widths of the keyframe linear interpolator.
package kfli_pkg;

    localparam int MAX_PAIRS  = 16;
    localparam int IDX_W      = $clog2(MAX_PAIRS);
    localparam int CNT_W      = IDX_W + 1;

    localparam int TIME_W     = 17;
    localparam int VAL_W      = 32;
    localparam int ENTRY_W    = TIME_W + VAL_W + 1;

    localparam int PAIR_CNT_W = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam int DV_W       = VAL_W + 1;
    localparam int DD_W       = TIME_W + 1;
    localparam int PROD_W     = DV_W + DD_W;
    localparam int QUO_W      = PROD_W + 1;
    localparam int SUM_W      = QUO_W + 1;
    localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

    localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(65536);

    localparam logic [CFG_ADDR_W-1:0] REG_PAIR_COUNT = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_FALLBACK   = CFG_ADDR_W'(1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_LOAD0,
        t_ST_WALK,
        t_ST_MUL,
        t_ST_DIVS,
        t_ST_DIVW,
        t_ST_FIN
    } t_state;

endpackage

// ===== src/kfli_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module kfli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/kfli_div.sv =====
// Restoring unsigned divider that retires one quotient bit per cycle.
module kfli_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [kfli_pkg::PROD_W-1:0]      i_dividend,
    input  logic [kfli_pkg::TIME_W-1:0]      i_divisor,
    output logic                             o_done,
    output logic [kfli_pkg::PROD_W-1:0]      o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [kfli_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [kfli_pkg::TIME_W-1:0]     r_rem;
    logic [kfli_pkg::TIME_W-1:0]     r_dsr;
    logic [kfli_pkg::PROD_W-1:0]     r_quo;

    logic [kfli_pkg::TIME_W:0]       w_rem_sh;
    logic                            w_ge;
    logic [kfli_pkg::TIME_W:0]       w_diff;

    assign w_rem_sh = {r_rem, r_quo[kfli_pkg::PROD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dsr});
    assign w_diff   = w_rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= kfli_pkg::DIV_CNT_W'(kfli_pkg::PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - kfli_pkg::DIV_CNT_W'(1);
                if (r_cnt == kfli_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[kfli_pkg::TIME_W-1:0] : w_rem_sh[kfli_pkg::TIME_W-1:0];
            r_quo <= {r_quo[kfli_pkg::PROD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/keyframe_linear_interpolator_core.sv =====
// Top level of the keyframe linear interpolator: keyframe table, table walk and blend.
//
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-----------------------------------------
// item      | in        | start high, busy low | i_opcode, i_entry_*, i_day_fraction
// result    | out       | o_valid, one cycle   | o_level_value, o_from_fallback
// config    | in        | i_cfg_we             | i_cfg_addr, i_cfg_wdata
//
// A write item leaves busy low. A query item walks the stored pairs through the registered
// read of the keyframe RAM; a blend then runs the multiply, the divider start, the wait on
// the one-bit-per-cycle divider and the sum. A zero count answers in the next cycle.
// Reset clears the control state, the valid flag and the config registers, not the RAM.
// The receiver cannot stall: each result is shown for exactly one cycle.
module keyframe_linear_interpolator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_opcode,
    input  logic [3:0]                           i_entry_index,
    input  logic [kfli_pkg::TIME_W-1:0]          i_entry_time,
    input  logic signed [kfli_pkg::VAL_W-1:0]    i_entry_value,
    input  logic                                 i_entry_invalid,
    input  logic signed [kfli_pkg::VAL_W-1:0]    i_day_fraction,
    input  logic                                 i_cfg_we,
    input  logic [kfli_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [kfli_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output logic                                 o_valid,
    output logic signed [kfli_pkg::VAL_W-1:0]    o_level_value,
    output logic                                 o_from_fallback
);

    kfli_pkg::t_state r_state, n_state;

    logic [kfli_pkg::PAIR_CNT_W-1:0]     r_pair_count;
    logic signed [kfli_pkg::VAL_W-1:0]   r_fallback;

    logic [kfli_pkg::CNT_W-1:0]          r_count, n_count;
    logic [kfli_pkg::TIME_W-1:0]         r_d, n_d;
    logic [kfli_pkg::IDX_W-1:0]          r_nxt, n_nxt;
    logic [kfli_pkg::TIME_W-1:0]         r_prev_t, n_prev_t;
    logic signed [kfli_pkg::VAL_W-1:0]   r_prev_v, n_prev_v;
    logic signed [kfli_pkg::DV_W-1:0]    r_dv, n_dv;
    logic signed [kfli_pkg::DD_W-1:0]    r_dd, n_dd;
    logic [kfli_pkg::TIME_W-1:0]         r_den, n_den;
    logic signed [kfli_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic                                r_neg, n_neg;
    logic signed [kfli_pkg::QUO_W-1:0]   r_q, n_q;
    logic signed [kfli_pkg::VAL_W-1:0]   r_level, n_level;
    logic                                r_fb, n_fb;
    logic                                r_valid, n_valid;

    logic                                w_accept;
    logic                                w_ram_we;
    logic [kfli_pkg::IDX_W-1:0]          w_ram_raddr;
    logic [kfli_pkg::ENTRY_W-1:0]        w_ram_rdata;
    logic [kfli_pkg::TIME_W-1:0]         w_rd_t;
    logic signed [kfli_pkg::VAL_W-1:0]   w_rd_v;
    logic                                w_rd_inv;
    logic [kfli_pkg::CNT_W-1:0]          w_nxt_p1;
    logic                                w_div_start;
    logic                                w_div_done;
    logic [kfli_pkg::PROD_W-1:0]         w_div_quo;
    logic [kfli_pkg::PROD_W-1:0]         w_abs;
    logic signed [kfli_pkg::PROD_W-1:0]  w_prod;
    logic signed [kfli_pkg::SUM_W-1:0]   w_sum;
    logic signed [kfli_pkg::QUO_W-1:0]   w_quo_s;

    assign busy     = (r_state != kfli_pkg::t_ST_IDLE);
    assign w_accept = start && !busy;
    assign w_ram_we = w_accept && (i_opcode == kfli_pkg::OP_WRITE) &&
                      (32'(i_entry_index) < kfli_pkg::MAX_PAIRS);

    assign w_rd_t   = w_ram_rdata[kfli_pkg::TIME_W-1:0];
    assign w_rd_v   = $signed(w_ram_rdata[kfli_pkg::TIME_W +: kfli_pkg::VAL_W]);
    assign w_rd_inv = w_ram_rdata[kfli_pkg::ENTRY_W-1];
    assign w_nxt_p1 = {1'b0, r_nxt} + kfli_pkg::CNT_W'(1);

    assign w_prod  = r_dv * r_dd;
    assign w_abs   = r_prod[kfli_pkg::PROD_W-1] ? $unsigned(-r_prod) : $unsigned(r_prod);
    assign w_quo_s = $signed({1'b0, w_div_quo});
    assign w_sum   = {{(kfli_pkg::SUM_W - kfli_pkg::VAL_W){r_prev_v[kfli_pkg::VAL_W-1]}},
                      r_prev_v} + {r_q[kfli_pkg::QUO_W-1], r_q};
    assign w_div_start = (r_state == kfli_pkg::t_ST_DIVS);

    always_comb begin
        unique case (r_state)
            kfli_pkg::t_ST_LOAD0: w_ram_raddr = kfli_pkg::IDX_W'(1);
            kfli_pkg::t_ST_WALK:  w_ram_raddr = w_nxt_p1[kfli_pkg::IDX_W-1:0];
            default:              w_ram_raddr = '0;
        endcase
    end

    kfli_ram #(
        .WIDTH (kfli_pkg::ENTRY_W),
        .DEPTH (kfli_pkg::MAX_PAIRS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (kfli_pkg::IDX_W'(i_entry_index)),
        .i_wdata ({i_entry_invalid, i_entry_value, i_entry_time}),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    kfli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_abs),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kfli_pkg::t_ST_IDLE: begin
                if (w_accept && (i_opcode == kfli_pkg::OP_QUERY) && (r_pair_count != '0)) begin
                    n_state = kfli_pkg::t_ST_LOAD0;
                end
            end
            kfli_pkg::t_ST_LOAD0: begin
                if (r_count == kfli_pkg::CNT_W'(1)) begin
                    n_state = kfli_pkg::t_ST_IDLE;
                end else begin
                    n_state = kfli_pkg::t_ST_WALK;
                end
            end
            kfli_pkg::t_ST_WALK: begin
                if (w_rd_inv) begin
                    n_state = kfli_pkg::t_ST_IDLE;
                end else if (w_rd_t >= r_d) begin
                    n_state = (w_rd_t <= r_prev_t) ? kfli_pkg::t_ST_IDLE : kfli_pkg::t_ST_MUL;
                end else if ((w_rd_t >= kfli_pkg::TIME_ONE) || (w_nxt_p1 == r_count)) begin
                    n_state = kfli_pkg::t_ST_IDLE;
                end
            end
            kfli_pkg::t_ST_MUL:  n_state = kfli_pkg::t_ST_DIVS;
            kfli_pkg::t_ST_DIVS: n_state = kfli_pkg::t_ST_DIVW;
            kfli_pkg::t_ST_DIVW: begin
                if (w_div_done) begin
                    n_state = kfli_pkg::t_ST_FIN;
                end
            end
            kfli_pkg::t_ST_FIN:  n_state = kfli_pkg::t_ST_IDLE;
            default:             n_state = kfli_pkg::t_ST_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_d      = r_d;
        n_nxt    = r_nxt;
        n_prev_t = r_prev_t;
        n_prev_v = r_prev_v;
        n_dv     = r_dv;
        n_dd     = r_dd;
        n_den    = r_den;
        n_prod   = r_prod;
        n_neg    = r_neg;
        n_q      = r_q;
        n_level  = r_level;
        n_fb     = r_fb;
        n_valid  = 1'b0;
        unique case (r_state)
            kfli_pkg::t_ST_IDLE: begin
                if (w_accept && (i_opcode == kfli_pkg::OP_QUERY)) begin
                    if (32'(r_pair_count) > kfli_pkg::MAX_PAIRS) begin
                        n_count = kfli_pkg::CNT_W'(kfli_pkg::MAX_PAIRS);
                    end else begin
                        n_count = kfli_pkg::CNT_W'(r_pair_count);
                    end
                    if (i_day_fraction < 0) begin
                        n_d = '0;
                    end else if (i_day_fraction > 32'sd65536) begin
                        n_d = kfli_pkg::TIME_ONE;
                    end else begin
                        n_d = i_day_fraction[kfli_pkg::TIME_W-1:0];
                    end
                    if (r_pair_count == '0) begin
                        n_level = r_fallback;
                        n_fb    = 1'b1;
                        n_valid = 1'b1;
                    end
                end
            end
            kfli_pkg::t_ST_LOAD0: begin
                n_prev_t = w_rd_t;
                n_prev_v = w_rd_v;
                n_nxt    = kfli_pkg::IDX_W'(1);
                if (r_count == kfli_pkg::CNT_W'(1)) begin
                    n_level = w_rd_v;
                    n_fb    = 1'b0;
                    n_valid = 1'b1;
                end
            end
            kfli_pkg::t_ST_WALK: begin
                n_dv  = {w_rd_v[kfli_pkg::VAL_W-1], w_rd_v} -
                        {r_prev_v[kfli_pkg::VAL_W-1], r_prev_v};
                n_dd  = $signed({1'b0, r_d}) - $signed({1'b0, r_prev_t});
                n_den = w_rd_t - r_prev_t;
                if (w_rd_inv) begin
                    n_level = r_prev_v;
                    n_fb    = 1'b0;
                    n_valid = 1'b1;
                end else if (w_rd_t >= r_d) begin
                    if (w_rd_t <= r_prev_t) begin
                        n_level = w_rd_v;
                        n_fb    = 1'b0;
                        n_valid = 1'b1;
                    end
                end else begin
                    n_prev_t = w_rd_t;
                    n_prev_v = w_rd_v;
                    n_nxt    = w_nxt_p1[kfli_pkg::IDX_W-1:0];
                    if ((w_rd_t >= kfli_pkg::TIME_ONE) || (w_nxt_p1 == r_count)) begin
                        n_level = w_rd_v;
                        n_fb    = 1'b0;
                        n_valid = 1'b1;
                    end
                end
            end
            kfli_pkg::t_ST_MUL: begin
                n_prod = w_prod;
            end
            kfli_pkg::t_ST_DIVS: begin
                n_neg = r_prod[kfli_pkg::PROD_W-1];
            end
            kfli_pkg::t_ST_DIVW: begin
                if (w_div_done) begin
                    n_q = r_neg ? -w_quo_s : w_quo_s;
                end
            end
            kfli_pkg::t_ST_FIN: begin
                n_fb    = 1'b0;
                n_valid = 1'b1;
                if (w_sum[kfli_pkg::SUM_W-1:kfli_pkg::VAL_W-1] == '0 ||
                    w_sum[kfli_pkg::SUM_W-1:kfli_pkg::VAL_W-1] == '1) begin
                    n_level = w_sum[kfli_pkg::VAL_W-1:0];
                end else if (w_sum[kfli_pkg::SUM_W-1]) begin
                    n_level = {1'b1, {(kfli_pkg::VAL_W-1){1'b0}}};
                end else begin
                    n_level = {1'b0, {(kfli_pkg::VAL_W-1){1'b1}}};
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfli_pkg::t_ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= '0;
            r_fallback   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == kfli_pkg::REG_PAIR_COUNT) begin
                r_pair_count <= i_cfg_wdata[kfli_pkg::PAIR_CNT_W-1:0];
            end else if (i_cfg_addr == kfli_pkg::REG_FALLBACK) begin
                r_fallback <= $signed(i_cfg_wdata[kfli_pkg::VAL_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count  <= n_count;
        r_d      <= n_d;
        r_nxt    <= n_nxt;
        r_prev_t <= n_prev_t;
        r_prev_v <= n_prev_v;
        r_dv     <= n_dv;
        r_dd     <= n_dd;
        r_den    <= n_den;
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_q      <= n_q;
        r_level  <= n_level;
        r_fb     <= n_fb;
    end

    assign o_valid         = r_valid;
    assign o_level_value   = r_level;
    assign o_from_fallback = r_fb;

endmodule
